### design/mcpm_pkg.sv
// shared widths, codes and control types of the capture period meter
package mcpm_pkg;

  localparam int unsigned CH_W    = 2;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned PER_W   = 22;
  localparam int unsigned EP_W    = 4;
  localparam int unsigned UPPER_W = 6;
  localparam int unsigned MASK_W  = 4;

  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned CHANNELS_DEF   = 4;
  localparam int unsigned CH_VISIT_MAX   = 4;

  localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;
  localparam logic [PER_W-1:0]  WRAP_ADD   = 22'h010000;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef struct packed {
    logic cap_we;
    logic tick_start;
    logic sel_next;
    logic rd_new;
    logic rd_old;
    logic load_out;
    logic tick_done;
  } mcpm_cmd_t;

  typedef struct packed {
    logic req_is_tick;
    logic pending;
  } mcpm_sts_t;

endpackage

### design/mcpm_if.sv
// request and result channel interfaces of the capture period meter
interface mcpm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [mcpm_pkg::CH_W-1:0]   channel;
  logic [mcpm_pkg::VAL_W-1:0]  capture_value;
  logic [mcpm_pkg::VAL_W-1:0]  counter_value;

  modport source (output valid, cmd, channel, capture_value, counter_value, input ready);
  modport sink   (input valid, cmd, channel, capture_value, counter_value, output ready);
endinterface

interface mcpm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mcpm_pkg::CH_W-1:0]   result_channel;
  logic                        high_freq;
  logic [mcpm_pkg::PER_W-1:0]  period_count;
  logic [mcpm_pkg::EP_W-1:0]   edge_periods;
  logic                        wrap_corrected;
  logic                        last;

  modport source (output valid, result_channel, high_freq, period_count, edge_periods,
                  wrap_corrected, last, input ready);
  modport sink   (input valid, result_channel, high_freq, period_count, edge_periods,
                  wrap_corrected, last, output ready);
endinterface

### design/mcpm_ram.sv
// generic single-write, single-read ram with registered read data
module mcpm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mcpm_ctrl.sv
// controller state machine sequencing captures and tick channel visits
module mcpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  mcpm_pkg::mcpm_sts_t sts_i,
  output mcpm_pkg::mcpm_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PICK = 3'd1;
  localparam logic [2:0] S_RNEW = 3'd2;
  localparam logic [2:0] S_ROLD = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (sts_i.req_is_tick) begin
            cmd_o.tick_start = 1'b1;
            state_d          = S_PICK;
          end else begin
            cmd_o.cap_we = 1'b1;
          end
        end
      end
      S_PICK: begin
        if (sts_i.pending) begin
          cmd_o.sel_next = 1'b1;
          state_d        = S_RNEW;
        end else begin
          cmd_o.tick_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RNEW: begin
        cmd_o.rd_new = 1'b1;
        state_d      = S_ROLD;
      end
      S_ROLD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = S_CALC;
      end
      S_CALC: begin
        cmd_o.load_out = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_PICK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/mcpm_datapath.sv
// datapath: capture rings, channel pointers, upper count and period arithmetic
module mcpm_datapath #(
  parameter int unsigned RING_DEPTH = mcpm_pkg::RING_DEPTH_DEF,
  parameter int unsigned CHANNELS   = mcpm_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcpm_pkg::MASK_W-1:0]   cfg_wdata_i,
  input  mcpm_pkg::mcpm_cmd_t           cmd_i,
  output mcpm_pkg::mcpm_sts_t           sts_o,
  input  logic                          req_cmd_i,
  input  logic [mcpm_pkg::CH_W-1:0]     req_channel_i,
  input  logic [mcpm_pkg::VAL_W-1:0]    req_capture_value_i,
  input  logic [mcpm_pkg::VAL_W-1:0]    req_counter_value_i,
  output logic [mcpm_pkg::CH_W-1:0]     rsp_result_channel_o,
  output logic                          rsp_high_freq_o,
  output logic [mcpm_pkg::PER_W-1:0]    rsp_period_count_o,
  output logic [mcpm_pkg::EP_W-1:0]     rsp_edge_periods_o,
  output logic                          rsp_wrap_corrected_o,
  output logic                          rsp_last_o
);

  localparam int unsigned NCH   = (CHANNELS < mcpm_pkg::CH_VISIT_MAX) ?
                                  CHANNELS : mcpm_pkg::CH_VISIT_MAX;
  localparam int unsigned CIW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PW    = $clog2(RING_DEPTH);
  localparam int unsigned DEPTH = NCH * RING_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = mcpm_pkg::VAL_W;
  localparam int unsigned PERW  = mcpm_pkg::PER_W;
  localparam int unsigned UW    = mcpm_pkg::UPPER_W;
  localparam logic [PW:0] RD_P  = (PW + 1)'(RING_DEPTH);
  localparam logic [AW:0] RD_A  = (AW + 1)'(RING_DEPTH);

  function automatic logic [PW-1:0] ring_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + RD_P - {1'b0, b};
    end
    return t[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] ram_addr(input logic [CIW-1:0] c, input logic [PW-1:0] p);
    logic [AW:0] t;
    t = (AW + 1)'(c) * RD_A + (AW + 1)'(p);
    return t[AW-1:0];
  endfunction

  logic [mcpm_pkg::MASK_W-1:0] cfg_mask_q;
  logic [PW-1:0]   wp_q  [NCH];
  logic [PW-1:0]   pp_q  [NCH];
  logic [PERW-1:0] lec_q [NCH];
  logic [UW-1:0]   upper_q;
  logic [NCH-1:0]  mask_q;
  logic            inc_q;
  logic [CIW-1:0]  cur_q;
  logic [PW-1:0]   edges_q;
  logic [VW-1:0]   newest_q;

  logic [CIW-1:0]  cap_idx;
  logic            cap_ok;
  logic [CIW-1:0]  low_idx;
  logic [CIW-1:0]  sel_idx;
  logic [PW-1:0]   wp_sel;
  logic [PW-1:0]   pp_sel;
  logic [PERW-1:0] lec_sel;
  logic [PW:0]     wp_inc;
  logic [PW-1:0]   wp_nxt;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [VW-1:0]   ram_rdata;
  logic            ram_we;

  logic [PERW-1:0] ext;
  logic [PERW-1:0] diff;
  logic            wrap;
  logic            same_upper;
  logic            high;
  logic [PW-1:0]   em1;
  logic [PW+3:0]   em1_x;
  logic [VW-1:0]   span;

  assign cap_idx = req_channel_i[CIW-1:0];
  assign cap_ok  = ({1'b0, req_channel_i} < (mcpm_pkg::CH_W + 1)'(NCH));

  always_comb begin
    low_idx = '0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_idx = CIW'(i);
      end
    end
  end

  always_comb begin
    if (cmd_i.cap_we) begin
      sel_idx = cap_idx;
    end else if (cmd_i.sel_next) begin
      sel_idx = low_idx;
    end else begin
      sel_idx = cur_q;
    end
  end

  assign wp_sel  = wp_q[sel_idx];
  assign pp_sel  = pp_q[sel_idx];
  assign lec_sel = lec_q[sel_idx];
  assign wp_inc  = {1'b0, wp_sel} + (PW + 1)'(1);
  assign wp_nxt  = (wp_inc == RD_P) ? '0 : wp_inc[PW-1:0];

  assign ram_we    = cmd_i.cap_we && cap_ok;
  assign ram_re    = cmd_i.rd_new || cmd_i.rd_old;
  assign ram_raddr = cmd_i.rd_old ? ram_addr(cur_q, ring_sub(wp_sel, edges_q))
                                  : ram_addr(cur_q, ring_sub(wp_sel, PW'(1)));

  mcpm_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr(cap_idx, wp_sel)),
    .wdata_i (req_capture_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // period arithmetic, oldest capture on ram_rdata during load_out
  assign ext        = {upper_q, newest_q};
  assign diff       = ext - lec_sel;
  assign wrap       = ext < lec_sel;
  assign same_upper = ext[PERW-1:VW] == lec_sel[PERW-1:VW];
  assign high       = edges_q >= PW'(2);
  assign em1        = edges_q - PW'(1);
  assign em1_x      = (PW + 4)'(em1);
  assign span       = newest_q - ram_rdata;

  assign sts_o.req_is_tick = req_cmd_i == mcpm_pkg::CMD_TICK;
  assign sts_o.pending     = |mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mask_q <= mcpm_pkg::MASK_RESET;
      upper_q    <= '0;
      mask_q     <= '0;
      inc_q      <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        wp_q[i]  <= '0;
        pp_q[i]  <= '0;
        lec_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_mask_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        wp_q[sel_idx] <= wp_nxt;
      end
      if (cmd_i.tick_start) begin
        for (int i = 0; i < NCH; i++) begin
          mask_q[i] <= cfg_mask_q[i] && (wp_q[i] != pp_q[i]);
        end
        inc_q <= ~req_counter_value_i[VW-1];
      end
      if (cmd_i.sel_next) begin
        mask_q[low_idx] <= 1'b0;
        pp_q[sel_idx]   <= wp_sel;
      end
      if (cmd_i.load_out) begin
        lec_q[sel_idx] <= ext;
      end
      if (cmd_i.tick_done && inc_q) begin
        upper_q <= upper_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_next) begin
      cur_q   <= low_idx;
      edges_q <= ring_sub(wp_sel, pp_sel);
    end
    if (cmd_i.rd_old) begin
      newest_q <= ram_rdata;
    end
    if (cmd_i.load_out) begin
      rsp_result_channel_o <= mcpm_pkg::CH_W'(cur_q);
      rsp_last_o           <= ~|mask_q;
      rsp_high_freq_o      <= high;
      if (high) begin
        rsp_period_count_o   <= PERW'(span);
        rsp_edge_periods_o   <= em1_x[3:0];
        rsp_wrap_corrected_o <= 1'b0;
      end else begin
        rsp_period_count_o   <= (wrap && same_upper) ? diff + mcpm_pkg::WRAP_ADD : diff;
        rsp_edge_periods_o   <= '0;
        rsp_wrap_corrected_o <= wrap;
      end
    end
  end

endmodule

### design/multichannel_capture_period_meter.sv
// top level of the multichannel capture period meter
// A capture request stores its value in the channel's ring if the channel is below the
// channel count. A tick request visits each enabled channel with new edges in turn:
// the single ring read port is read twice per channel (newest and oldest capture), and
// the one result register holds each result until it is taken. No request is taken
// until the tick's last result is taken. Results come out in channel order; the last
// one of a tick carries last. The ring is not cleared at reset: only entries written
// by captures are meaningful.
module multichannel_capture_period_meter #(
  parameter int unsigned RING_DEPTH = mcpm_pkg::RING_DEPTH_DEF,
  parameter int unsigned CHANNELS   = mcpm_pkg::CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mcpm_pkg::MASK_W-1:0] cfg_wdata_i,
  mcpm_req_if.sink                    req_i,
  mcpm_rsp_if.source                  rsp_o
);

  mcpm_pkg::mcpm_cmd_t cmd;
  mcpm_pkg::mcpm_sts_t sts;

  mcpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcpm_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_cmd_i            (req_i.cmd),
    .req_channel_i        (req_i.channel),
    .req_capture_value_i  (req_i.capture_value),
    .req_counter_value_i  (req_i.counter_value),
    .rsp_result_channel_o (rsp_o.result_channel),
    .rsp_high_freq_o      (rsp_o.high_freq),
    .rsp_period_count_o   (rsp_o.period_count),
    .rsp_edge_periods_o   (rsp_o.edge_periods),
    .rsp_wrap_corrected_o (rsp_o.wrap_corrected),
    .rsp_last_o           (rsp_o.last)
  );

endmodule
